@@ sv/msdfcc_pkg.sv @@
package msdfcc_pkg;

  localparam int LINE_DEPTH = 1024;
  localparam int COL_W     = $clog2(LINE_DEPTH);
  localparam int RW_W      = 11;
  localparam int THR_W     = 8;
  localparam int CHAN_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [RW_W-1:0]      ROW_WIDTH_RESET = RW_W'(64);
  localparam logic [THR_W-1:0]     THRESHOLD_RESET = THR_W'(33);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

endpackage

@@ sv/msdfcc_line_store.sv @@
module msdfcc_line_store
  import msdfcc_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [COL_W-1:0] waddr,
  input  pixel_t           wdata,
  input  logic             re,
  input  logic [COL_W-1:0] raddr,
  output pixel_t           rdata
);

  pixel_t mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

@@ sv/msdfcc_correct.sv @@
module msdfcc_correct
  import msdfcc_pkg::*;
(
  input  pixel_t           pixel,
  input  pixel_t           right,
  input  logic             has_right,
  input  pixel_t           down,
  input  logic             has_down,
  input  logic [THR_W-1:0] threshold,
  output pixel_t           fixed,
  output logic             replaced
);

  localparam logic [CHAN_W-1:0] MID_LEVEL = CHAN_W'(127);

  function automatic logic [CHAN_W-1:0] cross_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
    logic opposite;
    logic [CHAN_W-1:0] diff;
    opposite = ((a < MID_LEVEL) && (b > MID_LEVEL)) ||
               ((a > MID_LEVEL) && (b < MID_LEVEL));
    diff = (a > b) ? (a - b) : (b - a);
    return opposite ? diff : '0;
  endfunction

  logic [2:0]        clash;
  logic [CHAN_W-1:0] lo_ab;
  logic [CHAN_W-1:0] hi_ab;
  logic [CHAN_W-1:0] mid_hc;
  logic [CHAN_W-1:0] median;

  always_comb begin
    logic [CHAN_W-1:0] v;
    logic [CHAN_W-1:0] dr;
    logic [CHAN_W-1:0] dd;
    logic [CHAN_W-1:0] jump;
    for (int k = 0; k < 3; k++) begin
      v    = pixel[k*CHAN_W +: CHAN_W];
      dr   = has_right ? cross_diff(v, right[k*CHAN_W +: CHAN_W]) : '0;
      dd   = has_down  ? cross_diff(v, down[k*CHAN_W +: CHAN_W])  : '0;
      jump = (dr > dd) ? dr : dd;
      clash[k] = (jump > threshold);
    end
  end

  // median = max(min(a,b), min(max(a,b),c))
  assign lo_ab  = (pixel.blue < pixel.green) ? pixel.blue  : pixel.green;
  assign hi_ab  = (pixel.blue < pixel.green) ? pixel.green : pixel.blue;
  assign mid_hc = (hi_ab < pixel.red) ? hi_ab : pixel.red;
  assign median = (lo_ab > mid_hc) ? lo_ab : mid_hc;

  assign replaced = (clash[0] & clash[1]) | (clash[0] & clash[2]) | (clash[1] & clash[2]);

  always_comb begin
    if (replaced) begin
      fixed.red   = median;
      fixed.green = median;
      fixed.blue  = median;
    end else begin
      fixed = pixel;
    end
  end

endmodule

@@ sv/msdf_clash_correction.sv @@
// Each result passes the s1 registers and then the output registers after the request below its
//   pixel is accepted. Throughput: one request per cycle while the output is not stalled,
//   set by one line-store write and one read per pixel.
// Reset (synchronous, active high) clears the row position, the held-row flag, the
//   pipeline valids and sets row_width to 64, jump_threshold to 33. The line store is
//   not cleared and takes requests immediately.
module msdf_clash_correction
  import msdfcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RW_W-1:0]      cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAN_W-1:0]    in_blue,
  input  logic [CHAN_W-1:0]    in_green,
  input  logic [CHAN_W-1:0]    in_red,
  input  logic                 flush,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAN_W-1:0]    out_blue,
  output logic [CHAN_W-1:0]    out_green,
  output logic [CHAN_W-1:0]    out_red,
  output logic                 replaced
);

  logic [RW_W-1:0]  row_width;
  logic [THR_W-1:0] jump_threshold;
  logic [RW_W-1:0]  eff_width;

  logic [COL_W-1:0] column;
  logic [COL_W-1:0] column_next;
  logic             row_held;
  logic             row_held_next;
  logic [COL_W:0]   col_inc;
  logic             last;
  logic             accept;
  pixel_t           in_px;
  pixel_t           mem_px;

  logic             s1_valid;
  logic             s1_emit;
  logic             s1_has_right;
  logic             s1_has_down;
  pixel_t           s1_down;
  logic             s1_adv;
  pixel_t           cur;

  pixel_t           fix_px;
  logic             fix_replaced;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width      <= ROW_WIDTH_RESET;
      jump_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_WIDTH: row_width      <= cfg_data;
        REG_THRESHOLD: jump_threshold <= cfg_data[THR_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    if (row_width == '0) begin
      eff_width = RW_W'(1);
    end else if (row_width > RW_W'(LINE_DEPTH)) begin
      eff_width = RW_W'(LINE_DEPTH);
    end else begin
      eff_width = row_width;
    end
  end

  assign in_px   = '{red: in_red, green: in_green, blue: in_blue};
  assign col_inc = {1'b0, column} + (COL_W+1)'(1);
  assign last    = (RW_W'(col_inc) >= eff_width);
  assign s1_adv  = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign accept  = in_valid && in_ready;

  always_comb begin
    column_next   = last ? '0 : col_inc[COL_W-1:0];
    row_held_next = row_held;
    if (flush) begin
      if (!row_held) begin
        column_next = '0;
      end else if (last) begin
        row_held_next = 1'b0;
      end
    end else if (last) begin
      row_held_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      row_held <= 1'b0;
    end else if (accept) begin
      column   <= column_next;
      row_held <= row_held_next;
    end
  end

  // read the next column: right neighbor now, current pixel for the next request
  msdfcc_line_store u_line_store (
    .clk   (clk),
    .we    (accept && !flush),
    .waddr (column),
    .wdata (in_px),
    .re    (accept),
    .raddr (column_next),
    .rdata (mem_px)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit      <= row_held;
      s1_has_right <= !last;
      s1_has_down  <= !flush;
      s1_down      <= in_px;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      cur <= mem_px;
    end
  end

  msdfcc_correct u_correct (
    .pixel     (cur),
    .right     (mem_px),
    .has_right (s1_has_right),
    .down      (s1_down),
    .has_down  (s1_has_down),
    .threshold (jump_threshold),
    .fixed     (fix_px),
    .replaced  (fix_replaced)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid && s1_emit) begin
      out_blue  <= fix_px.blue;
      out_green <= fix_px.green;
      out_red   <= fix_px.red;
      replaced  <= fix_replaced;
    end
  end

endmodule

@@ sv/msdfcc_checker.sv @@
module msdfcc_checker
  import msdfcc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CHAN_W-1:0]    out_blue,
  input logic [CHAN_W-1:0]    out_green,
  input logic [CHAN_W-1:0]    out_red,
  input logic                 replaced
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable(out_blue) && $stable(out_green) && $stable(out_red) && $stable(replaced))
    else $error("output request changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_median_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid && replaced |-> (out_blue == out_green) && (out_green == out_red))
    else $error("replaced pixel channels differ");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without request two cycles earlier");

endmodule

bind msdf_clash_correction msdfcc_checker u_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top
  import msdfcc_pkg::*;
();

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_STALL    = 200;
  localparam int RANDOM_PIXELS = 600;
  localparam int MIN_CLASHES   = 2;
  localparam logic [CHAN_W-1:0] MIDPOINT = 8'd127;

  typedef struct packed {
    pixel_t pix;
    logic   replaced;
  } correction_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RW_W-1:0]      cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CHAN_W-1:0]    in_blue = '0;
  logic [CHAN_W-1:0]    in_green = '0;
  logic [CHAN_W-1:0]    in_red = '0;
  logic                 flush = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CHAN_W-1:0]    out_blue;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_red;
  logic                 replaced;

  // mirror of the block state
  pixel_t          line_copy [LINE_DEPTH];
  bit              line_written [LINE_DEPTH];
  int              next_column = 0;
  bit              row_stored = 1'b0;
  logic [RW_W-1:0] cur_width = ROW_WIDTH_RESET;
  logic [THR_W-1:0] cur_threshold = THRESHOLD_RESET;

  correction_t expected_corrections [$];
  int          errors = 0;
  int          cycle_count = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          long_stall_req = 1'b0;

  msdf_clash_correction DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int effective_width(logic [RW_W-1:0] w);
    if (w == 0) return 1;
    if (w > LINE_DEPTH) return LINE_DEPTH;
    return int'(w);
  endfunction

  function automatic logic [CHAN_W-1:0] side_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    if ((a < MIDPOINT && b > MIDPOINT) || (a > MIDPOINT && b < MIDPOINT))
      return (a > b) ? a - b : b - a;
    return '0;
  endfunction

  function automatic correction_t correct_pixel(pixel_t px, bit has_right, pixel_t right,
                                                bit has_down, pixel_t down);
    correction_t res;
    logic [23:0] p, r, d;
    logic [CHAN_W-1:0] v, dr, dd, a, b, c, mid;
    int clashes;
    p = px;
    r = right;
    d = down;
    clashes = 0;
    for (int k = 0; k < 3; k++) begin
      v  = p[8*k +: 8];
      dr = has_right ? side_gap(v, r[8*k +: 8]) : '0;
      dd = has_down ? side_gap(v, d[8*k +: 8]) : '0;
      if (((dr > dd) ? dr : dd) > cur_threshold) clashes++;
    end
    if (clashes >= MIN_CLASHES) begin
      a = px.blue;
      b = px.green;
      c = px.red;
      if (a > b) mid = (b > c) ? b : ((a > c) ? c : a);
      else       mid = (a > c) ? a : ((b > c) ? c : b);
      res.pix      = '{red: mid, green: mid, blue: mid};
      res.replaced = 1'b1;
    end else begin
      res.pix      = px;
      res.replaced = 1'b0;
    end
    return res;
  endfunction

  function automatic void predict_correction(pixel_t px, bit is_flush);
    int w, c;
    bit last, has_right;
    pixel_t right;
    w         = effective_width(cur_width);
    c         = next_column;
    last      = (c + 1 >= w);
    has_right = !last;
    right     = has_right ? line_copy[COL_W'(c + 1)] : '0;
    if (is_flush) begin
      if (!row_stored) begin
        next_column = 0;
        return;
      end
      expected_corrections.push_back(correct_pixel(line_copy[COL_W'(c)], has_right, right,
                                                   1'b0, '0));
    end else begin
      if (row_stored)
        expected_corrections.push_back(correct_pixel(line_copy[COL_W'(c)], has_right, right,
                                                     1'b1, px));
      line_copy[COL_W'(c)]    = px;
      line_written[COL_W'(c)] = 1'b1;
    end
    if (last) begin
      next_column = 0;
      row_stored  = !is_flush;
    end else begin
      next_column = c + 1;
    end
  endfunction

  function automatic logic [CHAN_W-1:0] random_channel();
    case ($urandom_range(0, 3))
      0: return CHAN_W'($urandom_range(0, 255));
      1: return CHAN_W'($urandom_range(0, 40));
      2: return CHAN_W'($urandom_range(215, 255));
      default: return CHAN_W'($urandom_range(124, 130));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.blue  = random_channel();
    px.green = random_channel();
    px.red   = random_channel();
    return px;
  endfunction

  task automatic send_request(pixel_t px, bit is_flush);
    int gap;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_blue  <= px.blue;
    in_green <= px.green;
    in_red   <= px.red;
    flush    <= is_flush;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_correction(px, is_flush);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_corrections.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic drain_held_row();
    while (row_stored) send_request(random_pixel(), 1'b1);
    if (next_column != 0) send_request(random_pixel(), 1'b1);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [RW_W-1:0] value);
    bit safe;
    wait_idle();
    // a wider row must not read entries that were never stored
    if (idx == REG_ROW_WIDTH && row_stored) begin
      safe = 1'b1;
      for (int i = 0; i < effective_width(value); i++)
        if (!line_written[COL_W'(i)]) safe = 1'b0;
      if (!safe) begin
        drain_held_row();
        wait_idle();
      end
    end
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROW_WIDTH) cur_width = value;
    else cur_threshold = value[THR_W-1:0];
  endtask

  initial begin : receiver
    int wait_cycles;
    wait_cycles = 0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        wait_cycles    = LONG_STALL;
      end else if (out_valid === 1'b1 && out_ready) begin
        wait_cycles = rx_idle ? $urandom_range(0, 10) : 0;
      end else if (wait_cycles > 0) begin
        wait_cycles--;
      end
      out_ready <= (wait_cycles == 0);
    end
  end

  always @(posedge clk) begin : check_results
    correction_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_corrections.size() == 0) begin
        $error("result with no request pending: b=%0d g=%0d r=%0d replaced=%0b",
               out_blue, out_green, out_red, replaced);
        errors++;
      end else begin
        want = expected_corrections.pop_front();
        if (out_blue !== want.pix.blue) begin
          $error("out_blue: expected %0d, got %0d", want.pix.blue, out_blue);
          errors++;
        end
        if (out_green !== want.pix.green) begin
          $error("out_green: expected %0d, got %0d", want.pix.green, out_green);
          errors++;
        end
        if (out_red !== want.pix.red) begin
          $error("out_red: expected %0d, got %0d", want.pix.red, out_red);
          errors++;
        end
        if (replaced !== want.replaced) begin
          $error("replaced: expected %0b, got %0b", want.replaced, replaced);
          errors++;
        end
      end
    end
  end

  task automatic test_reset_defaults();
    repeat (68) send_request(random_pixel(), 1'b0);
  endtask

  task automatic test_width_change_mid_row();
    write_register(REG_ROW_WIDTH, 2);
    repeat (3) send_request(random_pixel(), 1'b0);
    drain_held_row();
  endtask

  task automatic test_flush_cases();
    write_register(REG_ROW_WIDTH, 4);
    // partial first row is dropped
    repeat (3) send_request(random_pixel(), 1'b0);
    send_request(random_pixel(), 1'b1);
    repeat (6) send_request(random_pixel(), 1'b0);
    // flush mid-row drains the rest of the held row
    repeat (2) send_request(random_pixel(), 1'b1);
    repeat (4) send_request(random_pixel(), 1'b0);
    drain_held_row();
  endtask

  task automatic test_channel_jumps();
    write_register(REG_ROW_WIDTH, 2);
    send_request('{red: 127, green: 255, blue: 0}, 1'b0);
    send_request('{red: 128, green: 0, blue: 255}, 1'b0);
    send_request('{red: 255, green: 128, blue: 126}, 1'b0);
    send_request('{red: 0, green: 127, blue: 127}, 1'b0);
    send_request('{red: 200, green: 161, blue: 93}, 1'b0);
    send_request('{red: 50, green: 94, blue: 160}, 1'b0);
    send_request('{red: 110, green: 110, blue: 110}, 1'b0);
    send_request('{red: 143, green: 144, blue: 144}, 1'b0);
    drain_held_row();
  endtask

  task automatic test_threshold_extremes();
    write_register(REG_ROW_WIDTH, 0);
    write_register(REG_THRESHOLD, 0);
    send_request('{red: 128, green: 255, blue: 0}, 1'b0);
    send_request('{red: 126, green: 0, blue: 255}, 1'b0);
    send_request('{red: 127, green: 127, blue: 127}, 1'b0);
    send_request('{red: 0, green: 255, blue: 255}, 1'b0);
    write_register(REG_THRESHOLD, 255);
    send_request('{red: 0, green: 0, blue: 0}, 1'b0);
    send_request('{red: 255, green: 255, blue: 255}, 1'b0);
    send_request('{red: 0, green: 255, blue: 0}, 1'b0);
    drain_held_row();
  endtask

  task automatic test_output_backpressure();
    write_register(REG_ROW_WIDTH, 3);
    write_register(REG_THRESHOLD, 50);
    tx_idle = 1'b0;
    repeat (3) send_request(random_pixel(), 1'b0);
    long_stall_req = 1'b1;
    repeat (40) send_request(random_pixel(), 1'b0);
    wait_idle();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_frames();
    int pixels_sent;
    int phase_len;
    logic [RW_W-1:0] w;
    pixels_sent = 0;
    while (pixels_sent < RANDOM_PIXELS) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0: w = '0;
          1, 2, 3, 4, 5, 6: w = RW_W'($urandom_range(1, 12));
          default: w = RW_W'($urandom_range(13, 40));
        endcase
        write_register(REG_ROW_WIDTH, w);
      end
      if ($urandom_range(0, 1))
        write_register(REG_THRESHOLD,
                       RW_W'($urandom_range(0, 1) ? $urandom_range(0, 80)
                                                  : $urandom_range(0, 255)));
      phase_len = $urandom_range(30, 150);
      repeat (phase_len) begin
        if ($urandom_range(0, 15) == 0) begin
          send_request(random_pixel(), 1'b1);
        end else begin
          send_request(random_pixel(), 1'b0);
          pixels_sent++;
        end
      end
      if ($urandom_range(0, 1)) drain_held_row();
      wait_idle();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_width_change_mid_row();
    test_flush_cases();
    test_channel_jumps();
    test_threshold_extremes();
    test_output_backpressure();
    test_random_frames();
    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
